[hdl/timer_min_heap_defines.svh]
// assertion macros shared by the timer heap checker
// depends on nothing; included by the checker file only
`ifndef TIMER_MIN_HEAP_DEFINES_SVH
`define TIMER_MIN_HEAP_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define TMH_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("timer heap check failed");

// next-cycle implication
`define TMH_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("timer heap check failed");

`endif

[hdl/tmh_pkg.sv]
// types and codes of the timer min-heap
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package tmh_pkg;

    localparam int ID_BITS    = 6;
    localparam int ID_COUNT   = 64;
    localparam int DL_BITS    = 48;
    localparam int COUNT_BITS = 7;
    localparam int MAX_IDS    = 64;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [1:0] ST_OK             = 2'd0;
    localparam logic [1:0] ST_ADD_REFUSED    = 2'd1;
    localparam logic [1:0] ST_REMOVE_ABSENT  = 2'd2;
    localparam logic [1:0] ST_POP_EMPTY      = 2'd3;

    localparam int UOP_BITS = 4;
    localparam logic [UOP_BITS-1:0] UOP_NONE      = 4'd0;
    localparam logic [UOP_BITS-1:0] UOP_LOAD      = 4'd1;
    localparam logic [UOP_BITS-1:0] UOP_ERR       = 4'd2;
    localparam logic [UOP_BITS-1:0] UOP_ADD       = 4'd3;
    localparam logic [UOP_BITS-1:0] UOP_POPSEL    = 4'd4;
    localparam logic [UOP_BITS-1:0] UOP_REMSEL    = 4'd5;
    localparam logic [UOP_BITS-1:0] UOP_TAKE      = 4'd6;
    localparam logic [UOP_BITS-1:0] UOP_RD_PARENT = 4'd7;
    localparam logic [UOP_BITS-1:0] UOP_RD_CHILD  = 4'd8;
    localparam logic [UOP_BITS-1:0] UOP_WR_CUR    = 4'd9;
    localparam logic [UOP_BITS-1:0] UOP_WR_UP     = 4'd10;
    localparam logic [UOP_BITS-1:0] UOP_WR_DOWN   = 4'd11;
    localparam logic [UOP_BITS-1:0] UOP_OUT       = 4'd12;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ID_BITS-1:0] timer_id;
        logic [DL_BITS-1:0] deadline;
    } tmh_cmd_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  became_top;
        logic [ID_BITS-1:0]    popped_id;
        logic [DL_BITS-1:0]    popped_deadline;
        logic                  top_valid;
        logic [ID_BITS-1:0]    top_id;
        logic [DL_BITS-1:0]    top_deadline;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  id_present;
    } tmh_rsp_t;

    typedef struct packed {
        logic [UOP_BITS-1:0] uop;
    } tmh_ctl_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       full;
        logic       empty;
        logic       held_id;
        logic       s_zero;
        logic       s_is_last;
        logic       parent_gt;
        logic       lc_out;
        logic       cur_le_child;
    } tmh_flags_t;

endpackage

[hdl/tmh_datapath.sv]
// heap slot memory, position memory, presence bits and result register
// depends on tmh_pkg; driven by tmh_ctrl through micro-op commands
`timescale 1ns / 1ps

module tmh_datapath #(
    parameter int MAX_TIMERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tmh_pkg::tmh_cmd_t cmd,
    input  tmh_pkg::tmh_ctl_t ctl,
    output tmh_pkg::tmh_flags_t flags,
    output tmh_pkg::tmh_rsp_t rsp
);

    localparam int AW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int IW = AW + 2;
    localparam int IB = tmh_pkg::ID_BITS;
    localparam int DB = tmh_pkg::DL_BITS;
    localparam int EW = IB + DB;

    logic [EW-1:0] slot_mem [MAX_TIMERS];
    logic [AW-1:0] pos_mem  [tmh_pkg::ID_COUNT];

    logic [1:0]      op_reg;
    logic [IB-1:0]   id_reg;
    logic [IB-1:0]   tid_reg;
    logic [IB-1:0]   cur_id_reg;
    logic [DB-1:0]   cur_dl_reg;
    logic [AW-1:0]   s_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [tmh_pkg::ID_COUNT-1:0] held_reg;
    logic [tmh_pkg::ID_COUNT-1:0] held_next;
    logic [IB-1:0]   top_id_reg;
    logic [DB-1:0]   top_dl_reg;
    logic [1:0]      status_reg;
    logic            became_reg;
    logic [IB-1:0]   pid_reg;
    logic [DB-1:0]   pdl_reg;
    logic [EW-1:0]   rd_a_reg;
    logic [EW-1:0]   rd_b_reg;
    logic [AW-1:0]   pos_rd_reg;
    tmh_pkg::tmh_rsp_t rsp_reg;

    logic [AW-1:0]   parent_idx;
    logic [IW-1:0]   lc_w;
    logic [IW-1:0]   rc_w;
    logic [IW-1:0]   count_w;
    logic [AW-1:0]   last_idx;
    logic            pick_rc;
    logic [EW-1:0]   chosen;
    logic [AW-1:0]   addr_a;
    logic            wr_en;
    logic [EW-1:0]   wr_data;

    assign parent_idx = (s_reg - AW'(1)) >> 1;
    assign lc_w       = (IW'(s_reg) << 1) + IW'(1);
    assign rc_w       = lc_w + IW'(1);
    assign count_w    = IW'(count_reg);
    assign last_idx   = AW'(count_reg - CW'(1));
    assign pick_rc    = (rc_w < count_w) && (rd_a_reg[DB-1:0] > rd_b_reg[DB-1:0]);
    assign chosen     = pick_rc ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        addr_a  = last_idx;
        wr_en   = 1'b0;
        wr_data = {cur_id_reg, cur_dl_reg};
        case (ctl.uop)
            tmh_pkg::UOP_RD_PARENT: addr_a = parent_idx;
            tmh_pkg::UOP_RD_CHILD:  addr_a = AW'(lc_w);
            tmh_pkg::UOP_WR_CUR:    wr_en = 1'b1;
            tmh_pkg::UOP_WR_UP:
            begin
                wr_en   = 1'b1;
                wr_data = rd_a_reg;
            end
            tmh_pkg::UOP_WR_DOWN:
            begin
                wr_en   = 1'b1;
                wr_data = chosen;
            end
            default: addr_a = last_idx;
        endcase
    end

    // memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[s_reg]             <= wr_data;
            pos_mem[wr_data[EW-1:DB]]   <= s_reg;
        end
        if (ctl.uop == tmh_pkg::UOP_LOAD || ctl.uop == tmh_pkg::UOP_RD_PARENT ||
            ctl.uop == tmh_pkg::UOP_RD_CHILD)
        begin
            rd_a_reg <= slot_mem[addr_a];
        end
        if (ctl.uop == tmh_pkg::UOP_RD_CHILD)
        begin
            rd_b_reg <= slot_mem[AW'(rc_w)];
        end
        if (ctl.uop == tmh_pkg::UOP_LOAD)
        begin
            pos_rd_reg <= pos_mem[cmd.timer_id];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        held_next  = held_reg;
        case (ctl.uop)
            tmh_pkg::UOP_ADD:
            begin
                count_next       = count_reg + CW'(1);
                held_next[id_reg] = 1'b1;
            end
            tmh_pkg::UOP_TAKE:
            begin
                count_next         = count_reg - CW'(1);
                held_next[tid_reg] = 1'b0;
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s_reg == '0)
        begin
            top_id_reg <= wr_data[EW-1:DB];
            top_dl_reg <= wr_data[DB-1:0];
        end
        case (ctl.uop)
            tmh_pkg::UOP_LOAD:
            begin
                op_reg     <= cmd.opcode;
                id_reg     <= cmd.timer_id;
                cur_id_reg <= cmd.timer_id;
                cur_dl_reg <= cmd.deadline;
                status_reg <= tmh_pkg::ST_OK;
                became_reg <= 1'b0;
                pid_reg    <= '0;
                pdl_reg    <= '0;
            end
            tmh_pkg::UOP_ERR:
            begin
                case (op_reg)
                    tmh_pkg::OP_ADD:    status_reg <= tmh_pkg::ST_ADD_REFUSED;
                    tmh_pkg::OP_REMOVE: status_reg <= tmh_pkg::ST_REMOVE_ABSENT;
                    tmh_pkg::OP_POP:    status_reg <= tmh_pkg::ST_POP_EMPTY;
                    default:            status_reg <= tmh_pkg::ST_OK;
                endcase
            end
            tmh_pkg::UOP_ADD:    s_reg <= AW'(count_reg);
            tmh_pkg::UOP_POPSEL:
            begin
                s_reg   <= '0;
                tid_reg <= top_id_reg;
                pid_reg <= top_id_reg;
                pdl_reg <= top_dl_reg;
            end
            tmh_pkg::UOP_REMSEL:
            begin
                s_reg   <= pos_rd_reg;
                tid_reg <= id_reg;
            end
            // last entry fills the hole
            tmh_pkg::UOP_TAKE:
            begin
                cur_id_reg <= rd_a_reg[EW-1:DB];
                cur_dl_reg <= rd_a_reg[DB-1:0];
            end
            tmh_pkg::UOP_WR_CUR:  became_reg <= (s_reg == '0) && (op_reg == tmh_pkg::OP_ADD);
            tmh_pkg::UOP_WR_UP:   s_reg <= parent_idx;
            tmh_pkg::UOP_WR_DOWN: s_reg <= pick_rc ? AW'(rc_w) : AW'(lc_w);
            tmh_pkg::UOP_OUT:
            begin
                rsp_reg.status          <= status_reg;
                rsp_reg.became_top      <= became_reg;
                rsp_reg.popped_id       <= pid_reg;
                rsp_reg.popped_deadline <= pdl_reg;
                rsp_reg.top_valid       <= (count_reg != '0);
                rsp_reg.top_id          <= (count_reg != '0) ? top_id_reg : '0;
                rsp_reg.top_deadline    <= (count_reg != '0) ? top_dl_reg : '0;
                rsp_reg.entry_count     <= tmh_pkg::COUNT_BITS'(count_reg);
                rsp_reg.id_present      <= held_reg[id_reg];
            end
            default: s_reg <= s_reg;
        endcase
    end

    assign flags.opcode       = op_reg;
    assign flags.full         = (count_reg >= CW'(MAX_TIMERS));
    assign flags.empty        = (count_reg == '0);
    assign flags.held_id      = held_reg[id_reg];
    assign flags.s_zero       = (s_reg == '0);
    assign flags.s_is_last    = (IW'(s_reg) == count_w - IW'(1));
    assign flags.parent_gt    = (rd_a_reg[DB-1:0] > cur_dl_reg);
    assign flags.lc_out       = (lc_w >= count_w);
    assign flags.cur_le_child = (cur_dl_reg <= chosen[DB-1:0]);
    assign rsp                = rsp_reg;

endmodule

[hdl/tmh_ctrl.sv]
// sequencer of the timer heap: decode, take-out, sift up and sift down
// depends on tmh_pkg; commands tmh_datapath
`timescale 1ns / 1ps

module tmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  tmh_pkg::tmh_flags_t flags,
    output tmh_pkg::tmh_ctl_t   ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_TAKE   = 4'd2;
    localparam logic [3:0] S_UP_RD  = 4'd3;
    localparam logic [3:0] S_UP_CMP = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_CMP = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       first_reg;
    logic       first_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ctl.uop        = tmh_pkg::UOP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.uop    = tmh_pkg::UOP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (flags.opcode)
                    tmh_pkg::OP_ADD:
                    begin
                        if (flags.full || flags.held_id)
                        begin
                            ctl.uop    = tmh_pkg::UOP_ERR;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.uop    = tmh_pkg::UOP_ADD;
                            first_next = 1'b0;
                            state_next = S_UP_RD;
                        end
                    end
                    tmh_pkg::OP_REMOVE:
                    begin
                        ctl.uop    = flags.held_id ? tmh_pkg::UOP_REMSEL : tmh_pkg::UOP_ERR;
                        state_next = flags.held_id ? S_TAKE : S_FIN;
                    end
                    tmh_pkg::OP_POP:
                    begin
                        ctl.uop    = flags.empty ? tmh_pkg::UOP_ERR : tmh_pkg::UOP_POPSEL;
                        state_next = flags.empty ? S_FIN : S_TAKE;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_TAKE:
            begin
                ctl.uop = tmh_pkg::UOP_TAKE;
                if (flags.s_is_last)
                begin
                    state_next = S_FIN;
                end
                else if (flags.s_zero)
                begin
                    first_next = 1'b0;
                    state_next = S_DN_RD;
                end
                else
                begin
                    first_next = 1'b1;
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                if (flags.s_zero)
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_CUR;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.uop    = tmh_pkg::UOP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                first_next = 1'b0;
                if (flags.parent_gt)
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_UP;
                    state_next = S_UP_RD;
                end
                else if (first_reg)
                begin
                    // refilled hole not below its parent: sift down instead
                    state_next = S_DN_RD;
                end
                else
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_CUR;
                    state_next = S_FIN;
                end
            end
            S_DN_RD:
            begin
                if (flags.lc_out)
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_CUR;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.uop    = tmh_pkg::UOP_RD_CHILD;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (flags.cur_le_child)
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_CUR;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.uop    = tmh_pkg::UOP_WR_DOWN;
                    state_next = S_DN_RD;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctl.uop        = tmh_pkg::UOP_OUT;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

[hdl/timer_min_heap.sv]
// channel  direction  payload     handshake
// cmd      in         tmh_cmd_t   cmd_valid / cmd_stall
// rsp      out        tmh_rsp_t   rsp_valid / rsp_stall
//
// one operation at a time; add, remove and pop walk the heap level by level
// (read, then compare and write on the single-write slot memory), while a
// query or a refused operation walks no level.
// reset clears the count and presence bits at once; no clearing pass.
// a finished result waits in the output register; the next transfer is
// taken while it waits, and the sequencer holds only if the result is still there.
`timescale 1ns / 1ps

module timer_min_heap #(
    parameter int MAX_TIMERS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  tmh_pkg::tmh_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tmh_pkg::tmh_rsp_t rsp
);

    tmh_pkg::tmh_ctl_t   ctl;
    tmh_pkg::tmh_flags_t flags;

    tmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .flags     (flags),
        .ctl       (ctl)
    );

    tmh_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

[hdl/tmh_checker.sv]
// port-level checks of the timer heap, bound to the top level
// depends on tmh_pkg and timer_min_heap_defines.svh
`timescale 1ns / 1ps
`include "timer_min_heap_defines.svh"

module tmh_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input tmh_pkg::tmh_rsp_t rsp
);

    `TMH_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)
    `TMH_ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)
    `TMH_ASSERT_IMPLY(a_top_matches_count, clk, rst_n, rsp_valid, rsp.top_valid == (rsp.entry_count != '0) && rsp.entry_count <= 7'd64)
    `TMH_ASSERT_IMPLY(a_error_side_free, clk, rst_n, rsp_valid && rsp.status != tmh_pkg::ST_OK, !rsp.became_top && rsp.popped_id == '0 && rsp.popped_deadline == '0)

endmodule

bind timer_min_heap tmh_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
